[src/assert_macros.svh]
// Assertion macros for the peak picker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, inactive while reset is asserted.
`define GMDPP_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define GMDPP_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/gmdpp_pkg.sv]
// Package for the peak picker: sizes and the result record.
`default_nettype none
package gmdpp_pkg;

  localparam int MAX_PEAKS = 1024;
  localparam int POS_W     = 31;
  localparam int ADDR_W    = $clog2(MAX_PEAKS);
  localparam int CNT_W     = $clog2(MAX_PEAKS + 1);

  typedef struct packed {
    logic             accepted;
    logic [POS_W-1:0] peak_value;
    logic [CNT_W-1:0] peak_count;
    logic             overflow;
  } res_t;

endpackage
`default_nettype wire

[src/gmdpp_if.sv]
// Valid/ready channel interfaces for candidate and result items.
`default_nettype none
interface gmdpp_cand_if;
  logic                        valid;
  logic                        ready;
  logic [gmdpp_pkg::POS_W-1:0] position;
  logic                        first_of_list;

  modport source (output valid, output position, output first_of_list, input ready);
  modport sink   (input valid, input position, input first_of_list, output ready);
endinterface

interface gmdpp_res_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic [gmdpp_pkg::POS_W-1:0] peak_value;
  logic [gmdpp_pkg::CNT_W-1:0] peak_count;
  logic                        overflow;

  modport source (output valid, output accepted, output peak_value, output peak_count,
                  output overflow, input ready);
  modport sink   (input valid, input accepted, input peak_value, input peak_count,
                  input overflow, output ready);
endinterface
`default_nettype wire

[src/gmdpp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gmdpp_ram #(
  parameter int Width = 31,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

[src/gmdpp_ctrl.sv]
// Scan sequencer: compares a candidate against stored peaks, appends on accept.
`default_nettype none
module gmdpp_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cand_valid_i,
  output logic                              cand_ready_o,
  input  wire logic [gmdpp_pkg::POS_W-1:0]  cand_pos_i,
  input  wire logic                         cand_first_i,
  input  wire logic [gmdpp_pkg::POS_W-1:0]  min_sep_i,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output gmdpp_pkg::res_t                   res_o,
  output logic                              ram_we_o,
  output logic      [gmdpp_pkg::ADDR_W-1:0] ram_waddr_o,
  output logic      [gmdpp_pkg::POS_W-1:0]  ram_wdata_o,
  output logic                              ram_re_o,
  output logic      [gmdpp_pkg::ADDR_W-1:0] ram_raddr_o,
  input  wire logic [gmdpp_pkg::POS_W-1:0]  ram_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  localparam logic [gmdpp_pkg::CNT_W-1:0] CntMax = gmdpp_pkg::CNT_W'(gmdpp_pkg::MAX_PEAKS);

  state_e                       state_q, state_d;
  logic [gmdpp_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [gmdpp_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [gmdpp_pkg::CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic                         cmp_vld_q, cmp_vld_d;
  logic                         acc_q, acc_d;

  logic [gmdpp_pkg::POS_W-1:0]  gap;
  logic                         reject;
  logic                         full;

  // distance to the peak read back in the previous cycle
  assign gap    = (pos_q >= ram_rdata_i) ? (pos_q - ram_rdata_i) : (ram_rdata_i - pos_q);
  assign reject = cmp_vld_q && (gap < min_sep_i);
  assign full   = (cnt_q == CntMax);

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    cnt_d        = cnt_q;
    rd_idx_d     = rd_idx_q;
    cmp_vld_d    = 1'b0;
    acc_d        = acc_q;
    cand_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;
    ram_raddr_o  = rd_idx_q[gmdpp_pkg::ADDR_W-1:0];
    unique case (state_q)
      ST_IDLE: begin
        cand_ready_o = 1'b1;
        if (cand_valid_i) begin
          pos_d    = cand_pos_i;
          cnt_d    = cand_first_i ? '0 : cnt_q;
          rd_idx_d = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (reject || (!cmp_vld_q && (rd_idx_q == cnt_q))) begin
          acc_d   = !reject;
          state_d = ST_DONE;
        end else if (rd_idx_q != cnt_q) begin
          ram_re_o  = 1'b1;
          rd_idx_d  = rd_idx_q + 1'b1;
          cmp_vld_d = 1'b1;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
          if (acc_q && !full) begin
            ram_we_o = 1'b1;
            cnt_d    = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign ram_waddr_o = cnt_q[gmdpp_pkg::ADDR_W-1:0];
  assign ram_wdata_o = pos_q;

  always_comb begin
    res_o.accepted   = acc_q;
    res_o.peak_value = acc_q ? pos_q : '0;
    res_o.peak_count = (acc_q && !full) ? (cnt_q + 1'b1) : cnt_q;
    res_o.overflow   = acc_q && full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      acc_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
      acc_q     <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

endmodule
`default_nettype wire

[src/greedy_min_distance_peak_picker_unit.sv]
// Top level of the greedy minimum-distance peak picker.
`default_nettype none
`include "assert_macros.svh"
// Candidates arrive in priority order on cand_i; each one gives exactly one result
// item on res_o. A candidate becomes a peak unless its distance to some peak already
// stored in the current list is below min_separation (cfg_wdata_i, reset 1, write
// with cfg_we_i only while idle). first_of_list empties the store before the
// candidate is handled. Up to 1024 peaks are kept in an on-chip RAM; once it is full,
// accepted candidates are still reported but flagged with overflow and not stored.
// Scan: with N peaks stored when a candidate arrives (0 after first_of_list), the
// sequencer reads the N stored peaks in order from the single RAM read port, one
// per cycle, compares each returned peak with the candidate and then offers its
// result; the scan stops early at the first peak that is too close. One candidate
// is in flight at a time; a finished result waits in an output register so the
// next candidate can be taken while the result is still pending. The sequencer is
// back in idle in the cycle after handing its result over.
// No clearing pass is needed after reset: only entries below the peak count are
// ever read.
module greedy_min_distance_peak_picker_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  gmdpp_cand_if.sink                       cand_i,
  gmdpp_res_if.source                      res_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [gmdpp_pkg::POS_W-1:0] cfg_wdata_i
);

  // minimum separation register
  logic [gmdpp_pkg::POS_W-1:0] min_sep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sep_q <= gmdpp_pkg::POS_W'(1);
    end else if (cfg_we_i) begin
      min_sep_q <= cfg_wdata_i;
    end
  end

  // sequencer <-> peak store
  logic                         ram_we;
  logic [gmdpp_pkg::ADDR_W-1:0] ram_waddr;
  logic [gmdpp_pkg::POS_W-1:0]  ram_wdata;
  logic                         ram_re;
  logic [gmdpp_pkg::ADDR_W-1:0] ram_raddr;
  logic [gmdpp_pkg::POS_W-1:0]  ram_rdata;

  // sequencer <-> output register
  gmdpp_pkg::res_t res;
  logic            res_valid;
  logic            res_ready;

  logic            out_valid_q;
  gmdpp_pkg::res_t out_q;

  // the output slot takes a new item when empty or being drained this cycle
  assign res_ready = !out_valid_q || res_o.ready;

  gmdpp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cand_valid_i (cand_i.valid),
    .cand_ready_o (cand_i.ready),
    .cand_pos_i   (cand_i.position),
    .cand_first_i (cand_i.first_of_list),
    .min_sep_i    (min_sep_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  // peak store; written only when leaving the result state, so a write never
  // meets a read of the same entry in the same cycle
  gmdpp_ram #(
    .Width (gmdpp_pkg::POS_W),
    .Depth (gmdpp_pkg::MAX_PEAKS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.accepted   = out_q.accepted;
  assign res_o.peak_value = out_q.peak_value;
  assign res_o.peak_count = out_q.peak_count;
  assign res_o.overflow   = out_q.overflow;

  // checks
  `GMDPP_ASSERT_RST(a_busy_after_take, clk_i, rst_ni,
    (cand_i.valid && cand_i.ready) |=> !cand_i.ready,
    "candidate taken while a scan is still running")
  `GMDPP_ASSERT_RST(a_count_bound, clk_i, rst_ni,
    res_o.valid |-> (res_o.peak_count <= gmdpp_pkg::CNT_W'(gmdpp_pkg::MAX_PEAKS)),
    "peak count beyond store depth")
  `GMDPP_ASSERT_RST(a_overflow_full, clk_i, rst_ni,
    (res_o.valid && res_o.overflow) |->
      (res_o.accepted && (res_o.peak_count == gmdpp_pkg::CNT_W'(gmdpp_pkg::MAX_PEAKS))),
    "overflow without an accepted item on a full store")
  `GMDPP_ASSERT(a_no_write_idle, clk_i,
    ram_we |-> (res_valid && res_ready && res.accepted && !res.overflow),
    "peak store written outside an accepted result")

endmodule
`default_nettype wire
